// File: rtl/lqr_pkg.sv
// shared constants for the linear queue with reverse
package lqr_pkg;

    localparam int LQR_DEPTH = 128;
    localparam int WORD_W    = 32;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REV = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// File: rtl/lqr_mem.sv
// word store: one write port, one registered read port
module lqr_mem
    import lqr_pkg::*;
#(
    parameter int DEPTH = LQR_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WORD_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WORD_W-1:0]        o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/linear_queue_with_reverse_top.sv
// linear queue top: sequencer for enqueue, dequeue and reverse over one word store
// enqueue, unused op and reverse of an empty queue or of one word at slot 0 finish in the idle state;
// dequeue reads the head word in S_DEQ; reverse of n words first moves the words down to slot 0
// when the head is not at slot 0, then does n/2 swaps in place, all through the one word store
// one op at a time; the next is taken once the result sits in the output register and is not stalled
// synchronous active-low reset clears head and tail and sets the empty flag; the store is not cleared
module linear_queue_with_reverse_top
    import lqr_pkg::*;
#(
    parameter int DEPTH = LQR_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic signed [WORD_W-1:0] i_data_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [WORD_W-1:0] o_data_out,
    output logic [1:0]               o_status,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEQ    = 3'd1;
    localparam logic [2:0] S_CP_RD  = 3'd2;
    localparam logic [2:0] S_CP_WR  = 3'd3;
    localparam logic [2:0] S_SW_RDA = 3'd4;
    localparam logic [2:0] S_SW_RDB = 3'd5;
    localparam logic [2:0] S_SW_WRA = 3'd6;
    localparam logic [2:0] S_SW_WRB = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [AW-1:0]     r_a, n_a;
    logic [AW-1:0]     r_b, n_b;
    logic [WORD_W-1:0] r_tmp, n_tmp;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_data_out;
    logic [1:0]        r_status;
    logic              r_is_empty;
    logic              r_is_full;

    logic              load;
    logic [WORD_W-1:0] load_data;
    logic [1:0]        load_status;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [WORD_W-1:0] rdata;
    logic              accept;

    lqr_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_a         = r_a;
        n_b         = r_b;
        n_tmp       = r_tmp;
        load        = 1'b0;
        load_data   = '0;
        load_status = ST_OK;
        we          = 1'b0;
        waddr       = r_a;
        wdata       = rdata;
        raddr       = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_op)
                        OP_ENQ: begin
                            load = 1'b1;
                            if (!r_empty && r_tail == LAST) begin
                                load_status = ST_FULL;
                            end else begin
                                we    = 1'b1;
                                wdata = i_data_in;
                                if (r_empty) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b0;
                                    waddr   = '0;
                                end else begin
                                    n_tail = r_tail + AW'(1);
                                    waddr  = r_tail + AW'(1);
                                end
                            end
                        end
                        OP_DEQ: begin
                            if (r_empty) begin
                                load        = 1'b1;
                                load_status = ST_EMPTY;
                            end else begin
                                // head word comes out of the store next cycle
                                n_state = S_DEQ;
                            end
                        end
                        OP_REV: begin
                            if (r_empty || (r_tail == r_head && r_head == '0)) begin
                                load = 1'b1;
                            end else if (r_head != '0) begin
                                // move words down to slot 0 first, then swap in place if more than one word
                                n_a     = r_head;
                                n_b     = '0;
                                n_head  = '0;
                                n_tail  = r_tail - r_head;
                                n_state = S_CP_RD;
                            end else begin
                                n_a     = '0;
                                n_b     = r_tail;
                                n_state = S_SW_RDA;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                load      = 1'b1;
                load_data = rdata;
                if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else begin
                    n_head = r_head + AW'(1);
                end
                n_state = S_IDLE;
            end
            S_CP_RD: begin
                raddr   = r_a;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                we    = 1'b1;
                waddr = r_b;
                wdata = rdata;
                if (r_b == r_tail) begin
                    if (r_tail == '0) begin
                        // a single word only needs the move
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_a     = '0;
                        n_b     = r_tail;
                        n_state = S_SW_RDA;
                    end
                end else begin
                    n_a     = r_a + AW'(1);
                    n_b     = r_b + AW'(1);
                    n_state = S_CP_RD;
                end
            end
            S_SW_RDA: begin
                raddr   = r_a;
                n_state = S_SW_RDB;
            end
            S_SW_RDB: begin
                raddr   = r_b;
                n_tmp   = rdata;
                n_state = S_SW_WRA;
            end
            S_SW_WRA: begin
                we      = 1'b1;
                waddr   = r_a;
                wdata   = rdata;
                n_state = S_SW_WRB;
            end
            S_SW_WRB: begin
                we    = 1'b1;
                waddr = r_b;
                wdata = r_tmp;
                n_a   = r_a + AW'(1);
                n_b   = r_b - AW'(1);
                if (r_a + AW'(1) < r_b - AW'(1)) begin
                    n_state = S_SW_RDA;
                end else begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_tmp <= n_tmp;
        if (load) begin
            r_data_out <= load_data;
            r_status   <= load_status;
            r_is_empty <= n_empty;
            r_is_full  <= !n_empty && n_tail == LAST;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_is_empty  = r_is_empty;
    assign o_is_full   = r_is_full;

endmodule

// File: tb/tb_linear_queue_with_reverse_top.sv
// testbench for the linear queue with reverse: shadow queue predictor and per-word checker
`timescale 1ns / 1ps

module tb_linear_queue_with_reverse_top;
    import lqr_pkg::*;

    localparam int DEPTH = LQR_DEPTH;
    // op code 3 is unused by the block and must act as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic                     empty;
        logic                     full;
    } qres_t;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic [1:0]               i_op        = OP_ENQ;
    logic signed [WORD_W-1:0] i_data_in   = '0;
    logic                     i_out_stall = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [WORD_W-1:0] o_data_out;
    logic [1:0]               o_status;
    logic                     o_is_empty;
    logic                     o_is_full;

    // shadow copy of the queue
    logic signed [WORD_W-1:0] shadow_store [DEPTH];
    int                       shadow_head  = 0;
    int                       shadow_tail  = 0;
    bit                       shadow_empty = 1'b1;

    qres_t pending_results[$];
    int    errors     = 0;
    int    words_sent = 0;
    bit    quiet      = 1'b0;
    int    stall_left = 0;

    linear_queue_with_reverse_top #(.DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // applies one operation to the shadow queue and returns the word the block must give
    function automatic qres_t queue_apply(input logic [1:0] op,
                                          input logic signed [WORD_W-1:0] word);
        qres_t                    res;
        logic signed [WORD_W-1:0] flipped [DEPTH];
        int                       n;
        res.data   = '0;
        res.status = ST_OK;
        case (op)
            OP_ENQ: begin
                if (!shadow_empty && shadow_tail == DEPTH - 1) begin
                    res.status = ST_FULL;
                end else begin
                    if (shadow_empty) begin
                        shadow_head  = 0;
                        shadow_tail  = 0;
                        shadow_empty = 1'b0;
                    end else begin
                        shadow_tail++;
                    end
                    shadow_store[shadow_tail] = word;
                end
            end
            OP_DEQ: begin
                if (shadow_empty) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = shadow_store[shadow_head];
                    if (shadow_head == shadow_tail) begin
                        shadow_head  = 0;
                        shadow_tail  = 0;
                        shadow_empty = 1'b1;
                    end else begin
                        shadow_head++;
                    end
                end
            end
            OP_REV: begin
                if (!shadow_empty) begin
                    n = shadow_tail - shadow_head + 1;
                    for (int i = 0; i < n; i++) flipped[i] = shadow_store[shadow_tail - i];
                    for (int i = 0; i < n; i++) shadow_store[i] = flipped[i];
                    shadow_head = 0;
                    shadow_tail = n - 1;
                end
            end
            default: ;
        endcase
        res.empty = shadow_empty;
        res.full  = !shadow_empty && shadow_tail == DEPTH - 1;
        return res;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic signed [WORD_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_data_in  <= word;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(queue_apply(op, word));
        words_sent++;
    endtask

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 10) $display("mismatch at %0t: %s", $time, what);
    endtask

    // receiver stall: random bursts, no new burst starts while quiet
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 99) < 20) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : check_words
        qres_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected word data %0d status %0d",
                                     o_data_out, o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_data_out !== want.data || o_status !== want.status ||
                    o_is_empty !== want.empty || o_is_full !== want.full) begin
                    flag_error($sformatf(
                        "expected data %0d status %0d empty %0b full %0b, got %0d %0d %0b %0b",
                        want.data, want.status, want.empty, want.full,
                        o_data_out, o_status, o_is_empty, o_is_full));
                end
            end
        end
    end

    // edges of the data field, every op, empty and one-word cases, reverse with head moved
    task automatic test_directed();
        quiet = 1'b0;
        send_word(OP_DEQ, 32'sh12345678);
        send_word(OP_REV, -32'sd1);
        send_word(OP_NOP, 32'sh0);
        send_word(OP_ENQ, 32'sh7fffffff);
        send_word(OP_ENQ, 32'sh80000000);
        send_word(OP_ENQ, 32'sh0);
        send_word(OP_ENQ, -32'sd1);
        send_word(OP_ENQ, 32'sh55555555);
        send_word(OP_ENQ, 32'shaaaaaaaa);
        send_word(OP_NOP, -32'sd1);
        send_word(OP_REV, 32'sh0);
        send_word(OP_DEQ, -32'sd1);
        send_word(OP_REV, 32'sh7fffffff);
        repeat (5) send_word(OP_DEQ, 32'sh0);
        send_word(OP_DEQ, 32'sh0);
        send_word(OP_ENQ, 32'sh00c0ffee);
        send_word(OP_REV, 32'sh0);
        send_word(OP_NOP, 32'sh0);
        send_word(OP_DEQ, 32'sh0);
        // one word left away from slot 0, then reversed
        send_word(OP_ENQ, 32'sh11111111);
        send_word(OP_ENQ, 32'sh22222222);
        send_word(OP_DEQ, 32'sh0);
        send_word(OP_REV, 32'sh0);
        send_word(OP_ENQ, 32'sh33333333);
        send_word(OP_DEQ, 32'sh0);
        send_word(OP_DEQ, 32'sh0);
    endtask

    // full at the last slot, full with free slots ahead of the head, reverse of a full queue
    task automatic test_fill_and_drain();
        quiet = 1'b1;
        repeat (DEPTH) send_word(OP_ENQ, rand_word());
        quiet = 1'b0;
        repeat (2) send_word(OP_ENQ, rand_word());
        send_word(OP_REV, rand_word());
        repeat (10) send_word(OP_DEQ, rand_word());
        send_word(OP_ENQ, rand_word());
        send_word(OP_REV, rand_word());
        repeat (11) send_word(OP_ENQ, rand_word());
        quiet = 1'b1;
        repeat (DEPTH + 1) send_word(OP_DEQ, rand_word());
    endtask

    // segments with a random enqueue bias so the queue drifts between empty and full
    task automatic test_random_mix(input int count);
        int stop_at;
        int seg_len;
        int enq_pct;
        int r;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            seg_len = $urandom_range(10, 80);
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 55;
                default: enq_pct = 25;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            repeat (seg_len) begin
                r = $urandom_range(0, 99);
                if (r < 3)            send_word(OP_REV, rand_word());
                else if (r < enq_pct) send_word(OP_ENQ, rand_word());
                else                  send_word(OP_DEQ, rand_word());
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_drain();
        test_random_mix(1050);
        i_in_valid <= 1'b0;
        quiet = 1'b1;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("** linear_queue_with_reverse_top: PASSED **");
        end else begin
            $display("** linear_queue_with_reverse_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("** linear_queue_with_reverse_top: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lqr_pkg.sv
rtl/lqr_mem.sv
rtl/linear_queue_with_reverse_top.sv
tb/tb_linear_queue_with_reverse_top.sv
